[hdl/qslerp_pkg.sv]
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, constants and fixed-point helpers of the quaternion slerp unit.
// ----------------------------------------------------------------------------
package qslerp_pkg;

  localparam int QUAT_BITS = 16;
  localparam int BLEND_W   = 17;
  localparam int QW        = 32;  // normalized component, Q30
  localparam int VW        = 34;  // unnormalized component (sum of two Q30)

  localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;
  localparam logic [33:0]        NEAR_COS  = 34'd1073204953;
  // floor sqrt(2^60 - c^2) < 107374  <=>  c^2 > 2^60 - 107374^2
  localparam logic [59:0]        MID_C2    = 60'((64'd1 << 60) - 64'd107374 * 64'd107374);
  localparam logic [63:0]        TINY_LEN2 = 64'd11529215046;
  localparam logic signed [QW-1:0] ONE_Q30 = 32'sd1073741824;

  typedef logic signed [QUAT_BITS-1:0] comp_t;
  typedef logic signed [QW-1:0]        q30_t;
  typedef logic signed [VW-1:0]        vec_t;

  typedef enum logic [1:0] {
    PATH_SPH   = 2'd0,
    PATH_LIN   = 2'd1,
    PATH_MID   = 2'd2,
    PATH_IDENT = 2'd3
  } path_t;

  typedef struct packed {
    comp_t a_x;
    comp_t a_y;
    comp_t a_z;
    comp_t a_w;
    comp_t b_x;
    comp_t b_y;
    comp_t b_z;
    comp_t b_w;
    logic [BLEND_W-1:0] blend;
  } req_t;

  typedef struct packed {
    comp_t out_x;
    comp_t out_y;
    comp_t out_z;
    comp_t out_w;
    logic [1:0] path_used;
  } res_t;

  // bisection state carried along the arc pipeline
  typedef struct packed {
    q30_t [3:0] lo;
    q30_t [3:0] hi;
    logic [BLEND_W-1:0] t;
    path_t path;
    logic ok;
  } bis_t;

  // shift right, round to nearest, ties away from zero
  function automatic logic signed [63:0] rsr(input logic signed [63:0] x,
                                             input int unsigned s);
    logic [63:0] mag;
    if (s == 0) return x;
    mag = x[63] ? 64'(-x) : 64'(x);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return x[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic q30_t from_field(input comp_t s);
    if (QUAT_BITS <= 31)
      return q30_t'(64'(s) <<< ((QUAT_BITS <= 31) ? 31 - QUAT_BITS : 0));
    else
      return q30_t'(rsr(64'(s), 1));
  endfunction

  function automatic comp_t to_field(input q30_t v);
    logic signed [63:0] r;
    logic signed [63:0] lim;
    lim = (64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1;
    if (QUAT_BITS <= 31)
      r = rsr(64'(v), (QUAT_BITS <= 31) ? 31 - QUAT_BITS : 0);
    else
      r = 64'(v) * 64'sd2;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return comp_t'(r);
  endfunction

endpackage

[hdl/qslerp_front.sv]
// ----------------------------------------------------------------------------
// qslerp_front
// Dot product, shortest-arc flip, path choice and the linear / midpoint blend.
// ----------------------------------------------------------------------------
module qslerp_front import qslerp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_vld,
  input  req_t               req,
  output logic               out_vld,
  output path_t              path,
  output logic [BLEND_W-1:0] blend,
  output vec_t               na [4],
  output vec_t               nb [4]
);

  logic [4:0] vld;

  q30_t ac [4];
  q30_t bc [4];

  q30_t a1 [4], b1 [4];
  logic [BLEND_W-1:0] t1;
  logic signed [63:0] p1 [4];

  q30_t a2 [4], b2 [4];
  logic [BLEND_W-1:0] t2;
  logic [63:0] dabs2;

  q30_t a3 [4], b3 [4];
  logic [BLEND_W-1:0] t3;
  logic [33:0] c3;
  logic signed [32:0] diff3 [4];

  q30_t a4 [4], b4 [4];
  logic [BLEND_W-1:0] t4;
  logic [59:0] cc4;
  logic near4;
  logic signed [50:0] lp4 [4];
  vec_t mid4 [4];

  logic signed [63:0] dot_c;

  always_comb begin
    ac[0] = from_field(req.a_x);
    ac[1] = from_field(req.a_y);
    ac[2] = from_field(req.a_z);
    ac[3] = from_field(req.a_w);
    bc[0] = from_field(req.b_x);
    bc[1] = from_field(req.b_y);
    bc[2] = from_field(req.b_z);
    bc[3] = from_field(req.b_w);
    dot_c = p1[0] + p1[1] + p1[2] + p1[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products of the dot
      t1 <= (req.blend > BLEND_ONE) ? BLEND_ONE : req.blend;
      for (int i = 0; i < 4; i++) begin
        a1[i] <= ac[i];
        b1[i] <= bc[i];
        p1[i] <= 64'(ac[i]) * 64'(bc[i]);
      end
      // shortest arc
      t2    <= t1;
      dabs2 <= dot_c[63] ? 64'(-dot_c) : 64'(dot_c);
      for (int i = 0; i < 4; i++) begin
        a2[i] <= a1[i];
        b2[i] <= dot_c[63] ? -b1[i] : b1[i];
      end
      // cosine in Q30
      t3 <= t2;
      c3 <= 34'((dabs2 + (64'd1 << 29)) >> 30);
      for (int i = 0; i < 4; i++) begin
        a3[i]    <= a2[i];
        b3[i]    <= b2[i];
        diff3[i] <= 33'(b2[i]) - 33'(a2[i]);
      end
      // c^2 and blend products
      t4    <= t3;
      cc4   <= 60'(c3[29:0]) * 60'(c3[29:0]);
      near4 <= c3 > NEAR_COS;
      for (int i = 0; i < 4; i++) begin
        a4[i]   <= a3[i];
        b4[i]   <= b3[i];
        lp4[i]  <= diff3[i] * $signed({1'b0, t3});
        mid4[i] <= VW'(rsr(64'(a3[i]) + 64'(b3[i]), 1));
      end
      // path select
      blend <= t4;
      if (near4) begin
        path <= PATH_LIN;
      end else if (cc4 > MID_C2) begin
        path <= PATH_MID;
      end else begin
        path <= PATH_SPH;
      end
      for (int i = 0; i < 4; i++) begin
        nb[i] <= VW'(b4[i]);
        if (near4) begin
          na[i] <= VW'(64'(a4[i]) + rsr(64'(lp4[i]), 16));
        end else if (cc4 > MID_C2) begin
          na[i] <= mid4[i];
        end else begin
          na[i] <= VW'(a4[i]);
        end
      end
    end
  end

  assign out_vld = vld[4];

endmodule

[hdl/qslerp_norm.sv]
// ----------------------------------------------------------------------------
// qslerp_norm
// Pipelined vector normalize: squares, bit-serial square root (one root bit
// per stage), then four restoring dividers (one quotient bit per stage).
// ----------------------------------------------------------------------------
module qslerp_norm import qslerp_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_vld,
  input  vec_t          v [4],
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output q30_t          r [4],
  output logic          ok,
  output logic [SW-1:0] side_out
);

  localparam int SQ  = 32;
  localparam int DV  = 32;
  localparam int LAT = SQ + DV + 4;
  localparam int MW  = VW - 1;
  localparam int LW  = 33;

  typedef struct packed {
    logic [3:0][MW-1:0] mag;
    logic [3:0]         neg;
    logic               ok;
  } nc_t;

  logic          vld [LAT];
  logic [SW-1:0] sd  [LAT];

  logic [MW-1:0] mag_c [4];
  logic [MW-1:0] mag0  [4];
  logic [3:0]    neg0;
  logic [63:0]   sq0   [4];
  logic [63:0]   len2_c;

  logic [63:0] sn [0:SQ];
  logic [63:0] sr [0:SQ];
  nc_t         cs [0:SQ];
  logic [63:0] sn_next [SQ];
  logic [63:0] sr_next [SQ];

  logic [63:0]   dn [0:DV][4];
  logic [31:0]   dq [0:DV][4];
  logic [LW-1:0] dd [0:DV];
  nc_t           cd [0:DV];
  logic [63:0]   dn_next [DV][4];
  logic [31:0]   dq_next [DV][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = v[i][VW-1] ? MW'(-v[i]) : MW'(v[i]);
    end
    len2_c = sq0[0] + sq0[1] + sq0[2] + sq0[3];
  end

  // root stages
  always_comb begin
    logic [63:0] bitv;
    logic [63:0] trial;
    for (int j = 0; j < SQ; j++) begin
      bitv  = 64'd1 << (62 - 2 * j);
      trial = sr[j] + bitv;
      if (sn[j] >= trial) begin
        sn_next[j] = sn[j] - trial;
        sr_next[j] = (sr[j] >> 1) + bitv;
      end else begin
        sn_next[j] = sn[j];
        sr_next[j] = sr[j] >> 1;
      end
    end
  end

  // divide stages, quotient bit DV-1-j at stage j
  always_comb begin
    logic [64:0] dsh;
    for (int j = 0; j < DV; j++) begin
      dsh = 65'(dd[j]) << (DV - 1 - j);
      for (int i = 0; i < 4; i++) begin
        if ({1'b0, dn[j][i]} >= dsh) begin
          dn_next[j][i] = dn[j][i] - 64'(dsh);
          dq_next[j][i] = dq[j][i] | (32'd1 << (DV - 1 - j));
        end else begin
          dn_next[j][i] = dn[j][i];
          dq_next[j][i] = dq[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side_in;
      for (int k = 1; k < LAT; k++) sd[k] <= sd[k-1];

      for (int i = 0; i < 4; i++) begin
        mag0[i] <= mag_c[i];
        neg0[i] <= v[i][VW-1];
        sq0[i]  <= 64'(mag_c[i]) * 64'(mag_c[i]);
      end

      sn[0]     <= len2_c;
      sr[0]     <= '0;
      cs[0].ok  <= len2_c > TINY_LEN2;
      cs[0].neg <= neg0;
      for (int i = 0; i < 4; i++) cs[0].mag[i] <= mag0[i];

      for (int j = 0; j < SQ; j++) begin
        sn[j+1] <= sn_next[j];
        sr[j+1] <= sr_next[j];
        cs[j+1] <= cs[j];
      end

      // dividend = mag * 2^30 + len / 2, divisor = len
      dd[0] <= sr[SQ][LW-1:0];
      cd[0] <= cs[SQ];
      for (int i = 0; i < 4; i++) begin
        dn[0][i] <= (64'(cs[SQ].mag[i]) << 30) + 64'(sr[SQ][LW-1:1]);
        dq[0][i] <= '0;
      end

      for (int j = 0; j < DV; j++) begin
        dd[j+1] <= dd[j];
        cd[j+1] <= cd[j];
        for (int i = 0; i < 4; i++) begin
          dn[j+1][i] <= dn_next[j][i];
          dq[j+1][i] <= dq_next[j][i];
        end
      end

      ok <= cd[DV].ok;
      for (int i = 0; i < 4; i++) begin
        if (!cd[DV].ok) begin
          r[i] <= (i == 3) ? ONE_Q30 : '0;
        end else begin
          r[i] <= cd[DV].neg[i] ? -$signed(dq[DV][i]) : $signed(dq[DV][i]);
        end
      end
    end
  end

  assign out_vld  = vld[LAT-1];
  assign side_out = sd[LAT-1];

endmodule

[hdl/qslerp_bisect.sv]
// ----------------------------------------------------------------------------
// qslerp_bisect
// One arc bisection step: mid = normalize(lo + hi), then lo or hi takes mid
// according to one bit of the blend factor.
// ----------------------------------------------------------------------------
module qslerp_bisect import qslerp_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_vld,
  input  bis_t in_st,
  output logic out_vld,
  output bis_t out_st
);

  logic vld0;
  bis_t st0;
  vec_t sum0 [4];
  q30_t mid  [4];
  logic mid_ok;
  bis_t st_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (adv) begin
      vld0 <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st0 <= in_st;
      for (int i = 0; i < 4; i++) begin
        sum0[i] <= VW'($signed(in_st.lo[i])) + VW'($signed(in_st.hi[i]));
      end
    end
  end

  qslerp_norm #(.SW($bits(bis_t))) u_norm (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (vld0),
    .v        (sum0),
    .side_in  (st0),
    .out_vld  (out_vld),
    .r        (mid),
    .ok       (mid_ok),
    .side_out (st_n)
  );

  // a too-short mid comes back as identity, same as the arithmetic wants
  always_comb begin
    out_st = st_n;
    if (st_n.path == PATH_SPH && !st_n.t[BLEND_W-1] && (mid_ok || !mid_ok)) begin
      for (int i = 0; i < 4; i++) begin
        if (st_n.t[BIT]) begin
          out_st.lo[i] = mid[i];
        end else begin
          out_st.hi[i] = mid[i];
        end
      end
    end
  end

endmodule

[hdl/quaternion_slerp_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_slerp_unit
// Shortest-arc quaternion interpolation (linear, midpoint or spherical by arc
// bisection), normalized, rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
//   channel | signals                      | moves
//   --------+------------------------------+---------------------------------
//   req     | req_valid, req_ready, req    | a, b (Q1.15), blend (Q1.16)
//   res     | res_valid, res_ready, res    | out x/y/z/w (Q1.15), path_used
//
// One request per cycle while the output is not stalled. Pipeline from accept to result:
// 5 front stages, 68 per normalize (32 root-bit stages, 32 quotient-bit stages, 4 more),
// one normalize for the end points, 16 bisection steps of 69, one output reg.
// The whole pipe advances when the output register is empty or taken;
// req_ready is low only while a result waits at res. rst clears valid bits.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit import qslerp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int NSTEP = 16;

  logic adv;

  logic               f_vld;
  path_t              f_path;
  logic [BLEND_W-1:0] f_blend;
  vec_t               f_na [4];
  vec_t               f_nb [4];

  logic               e_vld;
  logic               e_bvld;
  q30_t               e_a [4];
  q30_t               e_b [4];
  logic               e_aok;
  logic               e_bok;
  logic [1:0]         e_path;
  logic [BLEND_W-1:0] e_t;

  bis_t chain [NSTEP+1];
  logic cv    [NSTEP+1];

  bis_t fin;
  q30_t pick [4];

  assign adv       = !res_valid || res_ready;
  assign req_ready = adv;

  qslerp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .in_vld  (req_valid),
    .req     (req),
    .out_vld (f_vld),
    .path    (f_path),
    .blend   (f_blend),
    .na      (f_na),
    .nb      (f_nb)
  );

  qslerp_norm #(.SW(2)) u_norm_a (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (f_vld),
    .v        (f_na),
    .side_in  (f_path),
    .out_vld  (e_vld),
    .r        (e_a),
    .ok       (e_aok),
    .side_out (e_path)
  );

  qslerp_norm #(.SW(BLEND_W)) u_norm_b (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (f_vld),
    .v        (f_nb),
    .side_in  (f_blend),
    .out_vld  (e_bvld),
    .r        (e_b),
    .ok       (e_bok),
    .side_out (e_t)
  );

  // non-spherical paths keep their result in lo and skip the updates
  always_comb begin
    chain[0].t    = e_t;
    chain[0].path = path_t'(e_path);
    chain[0].ok   = (path_t'(e_path) == PATH_SPH) ? (e_aok && e_bok) : e_aok;
    for (int i = 0; i < 4; i++) begin
      chain[0].lo[i] = e_a[i];
      chain[0].hi[i] = e_b[i];
    end
    cv[0] = e_vld && e_bvld;
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    qslerp_bisect #(.BIT(NSTEP - 1 - k)) u_step (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .in_vld  (cv[k]),
      .in_st   (chain[k]),
      .out_vld (cv[k+1]),
      .out_st  (chain[k+1])
    );
  end

  always_comb begin
    fin = chain[NSTEP];
    for (int i = 0; i < 4; i++) begin
      pick[i] = (fin.path == PATH_SPH && fin.t[BLEND_W-1]) ? fin.hi[i] : fin.lo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= cv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.ok) begin
        res.out_x     <= to_field(pick[0]);
        res.out_y     <= to_field(pick[1]);
        res.out_z     <= to_field(pick[2]);
        res.out_w     <= to_field(pick[3]);
        res.path_used <= fin.path;
      end else begin
        res.out_x     <= to_field('0);
        res.out_y     <= to_field('0);
        res.out_z     <= to_field('0);
        res.out_w     <= to_field(ONE_Q30);
        res.path_used <= PATH_IDENT;
      end
    end
  end

endmodule

[hdl/qslerp_checker.sv]
// ----------------------------------------------------------------------------
// qslerp_checker
// Port-level checks of the quaternion slerp unit, bound to the top level.
// ----------------------------------------------------------------------------
module qslerp_checker import qslerp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  localparam comp_t LIM      = comp_t'((64'd1 << (QUAT_BITS - 1)) - 64'd1);
  localparam comp_t MOST_NEG = comp_t'(64'd1 << (QUAT_BITS - 1));

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_ident: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.path_used == PATH_IDENT |->
      res.out_x == '0 && res.out_y == '0 && res.out_z == '0 && res.out_w == LIM)
    else $error("degenerate result is not identity");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.out_x != MOST_NEG && res.out_y != MOST_NEG &&
                  res.out_z != MOST_NEG && res.out_w != MOST_NEG)
    else $error("component outside saturation range");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request stalled with empty output");

endmodule

bind quaternion_slerp_unit qslerp_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
